### rtl/cctq_pkg.sv
// ----------------------------------------------------------------------------
// cctq_pkg
// Shared types and constants for the coalescing connect task queue.
// ----------------------------------------------------------------------------
package cctq_pkg;

	// Default sizes
	localparam int NUM_ENGINES_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 64;

	// Field widths fixed by the transaction format
	localparam int ID_W     = 6;
	localparam int STATUS_W = 3;
	localparam int CAP_W    = 7;

	// Capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Request codes
	typedef enum logic [1:0] {
		REQ_SUBMIT   = 2'd0,
		REQ_DISPATCH = 2'd1,
		REQ_SET      = 2'd2,
		REQ_GET      = 2'd3
	} req_type_t;

	// Submit outcome codes
	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_APPENDED = 2'd1,
		ACT_DUP      = 2'd2,
		ACT_REPLACED = 2'd3
	} submit_act_t;

	// Engine status codes
	localparam logic [STATUS_W-1:0] ST_NOT_CONN      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CONNECTING    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DISCONNECTING = 3'd2;

	// Result codes
	localparam logic RC_OK   = 1'b0;
	localparam logic RC_FULL = 1'b1;

endpackage

### rtl/cctq_if.sv
// ----------------------------------------------------------------------------
// cctq request / response channels
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface cctq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [5:0] engine_id;
	logic       want_connect;
	logic [2:0] new_status;

	modport source (output valid, req_type, engine_id, want_connect, new_status,
		input ready);
	modport sink (input valid, req_type, engine_id, want_connect, new_status,
		output ready);
endinterface

interface cctq_rsp_if;
	logic       valid;
	logic       ready;
	logic       result_code;
	logic [1:0] submit_action;
	logic       dispatch_valid;
	logic [5:0] dispatch_engine;
	logic       dispatch_connect;
	logic [2:0] status_out;

	modport source (output valid, result_code, submit_action, dispatch_valid,
		dispatch_engine, dispatch_connect, status_out, input ready);
	modport sink (input valid, result_code, submit_action, dispatch_valid,
		dispatch_engine, dispatch_connect, status_out, output ready);
endinterface

### rtl/cctq_ram.sv
// ----------------------------------------------------------------------------
// cctq_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cctq_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                    wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                    rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/coalescing_connect_task_queue_core.sv
// ----------------------------------------------------------------------------
// coalescing_connect_task_queue_core
// Coalescing connect/disconnect request queue with per-engine status table.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): one transaction per request: submit, dispatch, set or get.
//   rsp (source): exactly one response transaction per request.
//   cfg_we/cfg_wdata: writes queue_capacity; write only while idle.
// Sequencing: get and set use the status table only; a plain append also
//   writes the queue tail. A submit that hits a queued entry scans the queue
//   in S_QRD and S_QCHK per entry; a dispatch scans in S_QRD, S_QCHK and
//   S_SCHK per entry checked. Removing an entry compacts the tail in S_CRD
//   and S_CWR per entry behind it, so the worst case grows with QUEUE_DEPTH.
//   This is set by the single queue RAM port pair and the status RAM read.
// Throughput: one request at a time; req.ready is high only when idle.
// Reset: the status table is swept to not-connected, one engine per cycle,
//   with req.ready low. Queue count and capacity reset.
// Stall: a finished response waits in the output register; the block can
//   take the next request meanwhile, and holds its next response until the
//   output register is free.
// ----------------------------------------------------------------------------
module coalescing_connect_task_queue_core #(
	parameter int NUM_ENGINES = cctq_pkg::NUM_ENGINES_DEF,
	parameter int QUEUE_DEPTH = cctq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	cctq_req_if.sink                   req,
	cctq_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [cctq_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int EW   = $clog2(NUM_ENGINES);
	localparam int AW   = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = CW > cctq_pkg::CAP_W ? CW : cctq_pkg::CAP_W;
	localparam int SW   = cctq_pkg::STATUS_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_STAT, S_QRD, S_QCHK, S_SCHK, S_CRD, S_CWR,
		S_APPEND, S_FIN
	} state_t;

	state_t state_q;

	// engine id reduction table
	logic [EW-1:0] mod_tab [64];
	for (genvar g = 0; g < 64; g++) begin : g_mod
		assign mod_tab[g] = EW'(g % NUM_ENGINES);
	end

	// request registers
	cctq_pkg::req_type_t op_q;
	logic [EW-1:0]       eng_q;
	logic                kind_q;
	logic [SW-1:0]       nst_q;

	// sequencer registers
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       count_q;
	logic [EW-1:0]       clr_q;
	logic [EW-1:0]       qe_q;
	logic                qk_q;
	logic [cctq_pkg::CAP_W-1:0] cap_q;

	// result registers
	logic                   rc_q;
	cctq_pkg::submit_act_t  act_q;
	logic                   dv_q;
	logic [EW-1:0]          de_q;
	logic                   dc_q;
	logic [SW-1:0]          so_q;

	// output register
	logic                   ov_q;
	logic                   orc_q;
	logic [1:0]             oact_q;
	logic                   odv_q;
	logic [EW-1:0]          ode_q;
	logic                   odc_q;
	logic [SW-1:0]          oso_q;

	// RAM ports
	logic            q_we;
	logic [AW-1:0]   q_waddr, q_raddr;
	logic [EW:0]     q_wdata, q_rdata;
	logic            s_we;
	logic [EW-1:0]   s_waddr, s_raddr;
	logic [SW:0]     s_wdata, s_rdata;

	logic [CW-1:0]   idx_nxt;
	logic            full;
	logic [CMPW-1:0] cap_eff;
	logic            eligible;

	// queue entries {engine, kind}
	cctq_ram #(.W(EW + 1), .D(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	// status table entries {pending, status}
	cctq_ram #(.W(SW + 1), .D(NUM_ENGINES)) u_status (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// shared compare unit
	assign idx_nxt  = idx_q + CW'(1);
	assign cap_eff  = (CMPW'(cap_q) > CMPW'(QUEUE_DEPTH)) ? CMPW'(QUEUE_DEPTH) : CMPW'(cap_q);
	assign full     = CMPW'(count_q) >= cap_eff;
	assign eligible = (s_rdata[SW-1:0] != cctq_pkg::ST_CONNECTING) &&
		(s_rdata[SW-1:0] != cctq_pkg::ST_DISCONNECTING);

	// queue RAM control
	always_comb begin
		q_we    = 1'b0;
		q_waddr = idx_q[AW-1:0];
		q_wdata = q_rdata;
		q_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_CRD:    q_raddr = idx_nxt[AW-1:0];
			S_CWR:    q_we = 1'b1;
			S_APPEND: begin
				q_we    = 1'b1;
				q_waddr = count_q[AW-1:0];
				q_wdata = {eng_q, kind_q};
			end
			default: ;
		endcase
	end

	// status RAM control
	always_comb begin
		s_we    = 1'b0;
		s_waddr = eng_q;
		s_wdata = s_rdata;
		s_raddr = eng_q;
		unique case (state_q)
			S_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = '0;
			end
			S_IDLE: s_raddr = mod_tab[req.engine_id];
			S_STAT: begin
				if (op_q == cctq_pkg::REQ_SET) begin
					s_we    = 1'b1;
					s_wdata = {s_rdata[SW], nst_q};
				end else if (op_q == cctq_pkg::REQ_SUBMIT && !full && !s_rdata[SW]) begin
					s_we    = 1'b1;
					s_wdata = {1'b1, s_rdata[SW-1:0]};
				end
			end
			S_QCHK: s_raddr = q_rdata[EW:1];
			S_SCHK: begin
				s_waddr = qe_q;
				if (eligible) begin
					s_we    = 1'b1;
					s_wdata = {1'b0, qk_q ? cctq_pkg::ST_CONNECTING
						: cctq_pkg::ST_DISCONNECTING};
				end
			end
			default: ;
		endcase
	end

	assign req.ready            = (state_q == S_IDLE);
	assign rsp.valid            = ov_q;
	assign rsp.result_code      = orc_q;
	assign rsp.submit_action    = oact_q;
	assign rsp.dispatch_valid   = odv_q;
	assign rsp.dispatch_engine  = 6'(ode_q);
	assign rsp.dispatch_connect = odc_q;
	assign rsp.status_out       = oso_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cctq_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			// output register frees up; S_FIN refills it on its own
			if (ov_q && rsp.ready && state_q != S_FIN) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + EW'(1);
					if (clr_q == EW'(NUM_ENGINES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= cctq_pkg::req_type_t'(req.req_type);
						eng_q   <= mod_tab[req.engine_id];
						kind_q  <= req.want_connect;
						nst_q   <= req.new_status;
						rc_q    <= cctq_pkg::RC_OK;
						act_q   <= cctq_pkg::ACT_NONE;
						dv_q    <= 1'b0;
						de_q    <= '0;
						dc_q    <= 1'b0;
						so_q    <= '0;
						idx_q   <= '0;
						state_q <= S_STAT;
					end
				end
				S_STAT: begin
					unique case (op_q)
						cctq_pkg::REQ_GET: begin
							so_q    <= s_rdata[SW-1:0];
							state_q <= S_FIN;
						end
						cctq_pkg::REQ_SET: state_q <= S_FIN;
						cctq_pkg::REQ_SUBMIT: begin
							if (full) begin
								rc_q    <= cctq_pkg::RC_FULL;
								state_q <= S_FIN;
							end else if (!s_rdata[SW]) begin
								act_q   <= cctq_pkg::ACT_APPENDED;
								state_q <= S_APPEND;
							end else begin
								state_q <= S_QRD;
							end
						end
						cctq_pkg::REQ_DISPATCH: begin
							state_q <= (count_q == '0) ? S_FIN : S_QRD;
						end
					endcase
				end
				S_QRD: state_q <= S_QCHK;
				S_QCHK: begin
					qe_q <= q_rdata[EW:1];
					qk_q <= q_rdata[0];
					if (op_q == cctq_pkg::REQ_DISPATCH) begin
						state_q <= S_SCHK;
					end else if (q_rdata[EW:1] == eng_q) begin
						if (q_rdata[0] == kind_q) begin
							act_q   <= cctq_pkg::ACT_DUP;
							state_q <= S_FIN;
						end else begin
							act_q   <= cctq_pkg::ACT_REPLACED;
							state_q <= S_CRD;
						end
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_QRD;
					end
				end
				S_SCHK: begin
					if (eligible) begin
						dv_q    <= 1'b1;
						de_q    <= qe_q;
						dc_q    <= qk_q;
						state_q <= S_CRD;
					end else if (idx_nxt == count_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_QRD;
					end
				end
				S_CRD: begin
					if (idx_nxt < count_q) begin
						state_q <= S_CWR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= (op_q == cctq_pkg::REQ_SUBMIT) ? S_APPEND : S_FIN;
					end
				end
				S_CWR: begin
					idx_q   <= idx_nxt;
					state_q <= S_CRD;
				end
				S_APPEND: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						orc_q   <= rc_q;
						oact_q  <= act_q;
						odv_q   <= dv_q;
						ode_q   <= de_q;
						odc_q   <= dc_q;
						oso_q   <= so_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/cctq_checker.sv
// ----------------------------------------------------------------------------
// cctq_checker
// Port-level checks for the coalescing connect task queue.
// ----------------------------------------------------------------------------
module cctq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       result_code,
	input logic [1:0] submit_action,
	input logic       dispatch_valid,
	input logic [2:0] status_out
);

	// a held response stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(submit_action))
		else $error("response dropped while stalled");

	// refused submits report no action
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_code == cctq_pkg::RC_FULL |->
		submit_action == cctq_pkg::ACT_NONE && !dispatch_valid && status_out == '0)
		else $error("refused submit carries other fields");

	// dispatch response carries only dispatch fields
	a_disp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dispatch_valid |->
		submit_action == cctq_pkg::ACT_NONE && status_out == '0 &&
		result_code == cctq_pkg::RC_OK)
		else $error("dispatch response mixes fields");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

endmodule

bind coalescing_connect_task_queue_core cctq_checker u_cctq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.result_code(rsp.result_code),
	.submit_action(rsp.submit_action),
	.dispatch_valid(rsp.dispatch_valid),
	.status_out(rsp.status_out)
);

### sim/tb_coalescing_connect_task_queue_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coalescing_connect_task_queue_core
// Drives request transactions into the coalescing connect task queue and
// checks every response against a behavioral predictor that keeps its own
// queue, pending bits and status table. A directed table runs first, then
// random traffic over several capacity settings with bursty requests and
// a stalling response side.
// ----------------------------------------------------------------------------
module tb_coalescing_connect_task_queue_core;

	localparam int QD        = 64;
	localparam int NE        = 64;
	localparam int WDOG_MAX  = 20000;
	localparam int DRAIN_CYC = 400;

	// Response record
	typedef struct packed {
		logic       rc;
		logic [1:0] act;
		logic       dv;
		logic [5:0] de;
		logic       dc;
		logic [2:0] so;
	} rsp_t;

	// Directed row: request plus optional typed-in answer
	typedef struct {
		cctq_pkg::req_type_t op;
		logic [5:0] eng;
		logic       kind;
		logic [2:0] st;
		bit         fixed;
		rsp_t       ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [cctq_pkg::CAP_W-1:0] cfg_wdata = '0;

	cctq_req_if req ();
	cctq_rsp_if rsp ();

	coalescing_connect_task_queue_core dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	logic [5:0] mq_eng [QD];
	logic       mq_kind [QD];
	int         mq_cnt;
	logic [2:0] m_state [NE];
	bit         m_pend [NE];
	int         m_cap;

	rsp_t pending_rsp [$];
	bit   failed = 0;
	int   idle_cycles = 0;
	bit   rsp_stall_en = 1;

	function automatic void queue_drop(int pos);
		for (int i = pos; i + 1 < mq_cnt; i++) begin
			mq_eng[i]  = mq_eng[i+1];
			mq_kind[i] = mq_kind[i+1];
		end
		mq_cnt--;
	endfunction

	function automatic rsp_t predict_queue_op(cctq_pkg::req_type_t op, logic [5:0] eng,
		logic kind, logic [2:0] st);
		rsp_t r;
		int pos;
		int cap;
		r = '0;
		cap = (m_cap > QD) ? QD : m_cap;
		case (op)
			cctq_pkg::REQ_SUBMIT: begin
				if (mq_cnt >= cap) begin
					r.rc = cctq_pkg::RC_FULL;
				end else begin
					pos = -1;
					if (m_pend[eng])
						for (int i = 0; i < mq_cnt; i++)
							if (pos < 0 && mq_eng[i] == eng) pos = i;
					if (pos >= 0 && mq_kind[pos] == kind) begin
						r.act = cctq_pkg::ACT_DUP;
					end else begin
						r.act = cctq_pkg::ACT_APPENDED;
						if (pos >= 0) begin
							queue_drop(pos);
							r.act = cctq_pkg::ACT_REPLACED;
						end
						mq_eng[mq_cnt]  = eng;
						mq_kind[mq_cnt] = kind;
						mq_cnt++;
						m_pend[eng] = 1;
					end
				end
			end
			cctq_pkg::REQ_DISPATCH: begin
				for (int i = 0; i < mq_cnt; i++) begin
					if (m_state[mq_eng[i]] != cctq_pkg::ST_CONNECTING &&
						m_state[mq_eng[i]] != cctq_pkg::ST_DISCONNECTING) begin
						r.dv = 1'b1;
						r.de = mq_eng[i];
						r.dc = mq_kind[i];
						m_state[mq_eng[i]] = mq_kind[i] ? cctq_pkg::ST_CONNECTING
							: cctq_pkg::ST_DISCONNECTING;
						m_pend[mq_eng[i]] = 0;
						queue_drop(i);
						break;
					end
				end
			end
			cctq_pkg::REQ_SET: m_state[eng] = st;
			default: r.so = m_state[eng];
		endcase
		return r;
	endfunction

	// Response side: random stall pattern, compare against oldest expectation
	always @(posedge clk) begin
		rsp_t got;
		rsp_t exp_r;
		if (rsp.valid && rsp.ready) begin
			got = {rsp.result_code, rsp.submit_action, rsp.dispatch_valid,
				rsp.dispatch_engine, rsp.dispatch_connect, rsp.status_out};
			if (pending_rsp.size() == 0) begin
				$error("unexpected response transaction");
				failed = 1;
			end else begin
				exp_r = pending_rsp.pop_front();
				if (got.rc !== exp_r.rc) begin
					$error("result_code exp %0d got %0d", exp_r.rc, got.rc); failed = 1;
				end
				if (got.act !== exp_r.act) begin
					$error("submit_action exp %0d got %0d", exp_r.act, got.act); failed = 1;
				end
				if (got.dv !== exp_r.dv) begin
					$error("dispatch_valid exp %0d got %0d", exp_r.dv, got.dv); failed = 1;
				end
				if (got.de !== exp_r.de) begin
					$error("dispatch_engine exp %0d got %0d", exp_r.de, got.de); failed = 1;
				end
				if (got.dc !== exp_r.dc) begin
					$error("dispatch_connect exp %0d got %0d", exp_r.dc, got.dc); failed = 1;
				end
				if (got.so !== exp_r.so) begin
					$error("status_out exp %0d got %0d", exp_r.so, got.so); failed = 1;
				end
			end
		end
		// stall pattern: runs of stall / free, sometimes fully free
		if (!rsp_stall_en) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("FAIL");
			$finish;
		end
	end

	// Issue one request transaction; hold valid across back-to-back items
	task automatic send_req(cctq_pkg::req_type_t op, logic [5:0] eng, logic kind,
		logic [2:0] st, bit fixed, rsp_t ans, bit keep);
		rsp_t p;
		req.valid        <= 1'b1;
		req.req_type     <= op;
		req.engine_id    <= eng;
		req.want_connect <= kind;
		req.new_status   <= st;
		do @(posedge clk); while (!req.ready);
		p = predict_queue_op(op, eng, kind, st);
		if (fixed && p !== ans) begin
			$error("directed row: predictor exp %h table %h", p, ans);
			failed = 1;
		end
		pending_rsp.push_back(fixed ? ans : p);
		if (!keep) req.valid <= 1'b0;
	endtask

	task automatic drain_all();
		int n;
		n = 0;
		while (pending_rsp.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_cap(logic [cctq_pkg::CAP_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		m_cap = v;
	endtask

	function automatic rsp_t mk(logic rc, logic [1:0] act, logic dv, logic [5:0] de,
		logic dc, logic [2:0] so);
		return {rc, act, dv, de, dc, so};
	endfunction

	// Random request with mostly well-formed traffic over a small engine set
	task automatic random_item(int eng_hi, bit keep);
		cctq_pkg::req_type_t op;
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) op = cctq_pkg::REQ_SUBMIT;
		else if (r < 75) op = cctq_pkg::REQ_DISPATCH;
		else if (r < 88) op = cctq_pkg::REQ_SET;
		else op = cctq_pkg::REQ_GET;
		send_req(op, 6'($urandom_range(0, eng_hi)), 1'($urandom),
			(r % 3 == 0) ? 3'($urandom) : 3'($urandom_range(0, 2)), 0, '0, keep);
	endtask

	initial begin
		row_t dir_tab [$];
		int left;
		int phase_caps [6];
		int eng_hi;

		req.valid = 1'b0;
		req.req_type = cctq_pkg::REQ_SUBMIT;
		req.engine_id = '0;
		req.want_connect = 1'b0;
		req.new_status = '0;

		mq_cnt = 0;
		m_cap = cctq_pkg::CAP_RESET;
		for (int i = 0; i < NE; i++) begin
			m_state[i] = cctq_pkg::ST_NOT_CONN;
			m_pend[i] = 0;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset state, dedup, replace, dispatch, extremes
		dir_tab = '{
			'{cctq_pkg::REQ_GET, 6'd63, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_NONE, 0, 0, 0, cctq_pkg::ST_NOT_CONN)},
			'{cctq_pkg::REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_NONE, 0, 0, 0, 0)},
			'{cctq_pkg::REQ_SUBMIT, 6'd5, 1'b1, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_APPENDED, 0, 0, 0, 0)},
			'{cctq_pkg::REQ_SUBMIT, 6'd5, 1'b1, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_DUP, 0, 0, 0, 0)},
			'{cctq_pkg::REQ_SUBMIT, 6'd63, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_APPENDED, 0, 0, 0, 0)},
			'{cctq_pkg::REQ_SUBMIT, 6'd5, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_REPLACED, 0, 0, 0, 0)},
			'{cctq_pkg::REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_NONE, 1, 63, 0, 0)},
			'{cctq_pkg::REQ_GET, 6'd63, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_NONE, 0, 0, 0,
					cctq_pkg::ST_DISCONNECTING)},
			'{cctq_pkg::REQ_SET, 6'd5, 1'b0, 3'd1, 0, '0},
			'{cctq_pkg::REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_NONE, 0, 0, 0, 0)},
			'{cctq_pkg::REQ_SET, 6'd5, 1'b0, 3'd7, 0, '0},
			'{cctq_pkg::REQ_GET, 6'd5, 1'b0, 3'd0, 1,
				mk(cctq_pkg::RC_OK, cctq_pkg::ACT_NONE, 0, 0, 0, 3'd7)},
			'{cctq_pkg::REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 0, '0},
			'{cctq_pkg::REQ_SET, 6'd0, 1'b1, 3'd0, 0, '0},
			'{cctq_pkg::REQ_SUBMIT, 6'd0, 1'b1, 3'd5, 0, '0},
			'{cctq_pkg::REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 0, '0},
			'{cctq_pkg::REQ_SET, 6'd63, 1'b0, 3'd0, 0, '0},
			'{cctq_pkg::REQ_GET, 6'd0, 1'b0, 3'd0, 0, '0}
		};
		foreach (dir_tab[i])
			send_req(dir_tab[i].op, dir_tab[i].eng, dir_tab[i].kind, dir_tab[i].st,
				dir_tab[i].fixed, dir_tab[i].ans, (i + 1 < dir_tab.size()));
		drain_all();

		// Capacity zero: submit refused, get still served
		write_cap(7'd0);
		send_req(cctq_pkg::REQ_SUBMIT, 6'd9, 1'b1, 3'd0, 1,
			mk(cctq_pkg::RC_FULL, cctq_pkg::ACT_NONE, 0, 0, 0, 0), 1);
		send_req(cctq_pkg::REQ_GET, 6'd9, 1'b0, 3'd0, 0, '0, 0);
		drain_all();

		// Random phases across capacities, max value saturates to depth
		phase_caps = '{64, 1, 127, 3, 8, 65};
		foreach (phase_caps[p]) begin
			write_cap(cctq_pkg::CAP_W'(phase_caps[p]));
			left = 200;
			rsp_stall_en = (p != 2);
			eng_hi = (p == 2 || p == 5) ? 63 : 15;
			while (left > 0) begin
				int burst;
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && left > 0; b++) begin
					random_item(eng_hi, (b + 1 < burst) && (left > 1));
					left--;
				end
				repeat ($urandom_range(1, 6)) @(posedge clk);
				// at most one hold-off per phase until the block has answered everything
				if (left == 100) drain_all();
			end
			drain_all();
		end

		drain_all();
		if (!failed && pending_rsp.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/cctq_pkg.sv
rtl/cctq_if.sv
rtl/cctq_ram.sv
rtl/coalescing_connect_task_queue_core.sv
rtl/cctq_checker.sv
sim/tb_coalescing_connect_task_queue_core.sv
